// ===== rtl/edc_pkg.sv =====
package edc_pkg;

  localparam int MaxLen = 64;
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int OutW   = 7;

  typedef logic [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    TokNop,
    TokAppend,
    TokStep,
    TokFinish
  } tok_kind_e;

  // idx: append target cell, or first length on finish
  // left/diag: new and old row value of the cell to the left on a step
  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] sym;
    len_t       idx;
    len_t       left;
    len_t       diag;
    len_t       distance;
    len_t       longer;
    logic       err;
  } tok_t;

  function automatic logic [OutW-1:0] fit_out(len_t v);
    logic [LenW+OutW-1:0] ext;
    ext = {{OutW{1'b0}}, v};
    return ext[OutW-1:0];
  endfunction

endpackage

// ===== rtl/edc_cell.sv =====
module edc_cell import edc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  len_t index_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic       active_q, active_d;
  logic [7:0] char_q, char_d;
  len_t       dp_q, dp_d;
  tok_t       tok_q, tok_d;

  logic [LenW:0] up1, left1, diag1, m1, best;

  always_comb begin
    up1   = {1'b0, dp_q} + (LenW+1)'(1);
    left1 = {1'b0, tok_i.left} + (LenW+1)'(1);
    diag1 = {1'b0, tok_i.diag} + ((char_q == tok_i.sym) ? (LenW+1)'(0) : (LenW+1)'(1));
    m1    = (up1 < left1) ? up1 : left1;
    best  = (m1 < diag1) ? m1 : diag1;
  end

  always_comb begin
    active_d = active_q;
    char_d   = char_q;
    dp_d     = dp_q;
    tok_d    = tok_i;
    unique case (tok_i.kind)
      TokAppend: begin
        if (tok_i.idx == index_i) begin
          active_d = 1'b1;
          char_d   = tok_i.sym;
          dp_d     = index_i;
        end
      end
      TokStep: begin
        if (active_q) begin
          dp_d       = best[LenW-1:0];
          tok_d.left = best[LenW-1:0];
          tok_d.diag = dp_q;
        end
      end
      TokFinish: begin
        if (tok_i.idx == index_i) begin
          tok_d.distance = dp_q;
        end
        active_d = 1'b0;
        dp_d     = index_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      dp_q       <= index_i;
      tok_q.kind <= TokNop;
    end else if (en_i) begin
      active_q <= active_d;
      dp_q     <= dp_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      char_q <= char_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/edc_front.sv =====
module edc_front import edc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       accept_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] symbol_i,
  output tok_t       tok_o
);

  typedef enum logic [1:0] {
    ModeAppend = 2'd0,
    ModeStep   = 2'd1,
    ModeFinish = 2'd2,
    ModeUnused = 2'd3
  } mode_e;

  len_t first_q, first_d;
  len_t second_q, second_d;
  logic err_q, err_d;
  tok_t tok_q, tok_d;

  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    err_d       = err_q;
    tok_d       = tok_q;
    tok_d.kind  = TokNop;
    tok_d.sym   = symbol_i;
    if (accept_i) begin
      unique case (mode_e'(mode_i))
        ModeAppend: begin
          if (second_q != '0 || first_q >= len_t'(MaxLen)) begin
            err_d = 1'b1;
          end else begin
            first_d    = first_q + len_t'(1);
            tok_d.kind = TokAppend;
            tok_d.idx  = first_q + len_t'(1);
          end
        end
        ModeStep: begin
          if (second_q >= len_t'(MaxLen)) begin
            err_d = 1'b1;
          end else begin
            second_d   = second_q + len_t'(1);
            tok_d.kind = TokStep;
            tok_d.left = second_q + len_t'(1);
            tok_d.diag = second_q;
          end
        end
        ModeFinish: begin
          tok_d.kind     = TokFinish;
          tok_d.idx      = first_q;
          tok_d.distance = second_q;
          tok_d.longer   = (first_q > second_q) ? first_q : second_q;
          tok_d.err      = err_q;
          first_d        = '0;
          second_d       = '0;
          err_d          = 1'b0;
        end
        ModeUnused: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= '0;
      second_q   <= '0;
      err_q      <= 1'b0;
      tok_q.kind <= TokNop;
    end else if (en_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      err_q    <= err_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/edit_distance_engine.sv =====
// channel | direction | handshake             | fields
// in      | input     | in_valid_i/in_stall_o   | mode_i, symbol_i
// out     | output    | out_valid_o/out_stall_i | distance_o, longer_length_o, input_error_o
//
// One input word per cycle while in_stall_o is low. Each word becomes a token that walks
// the row of MaxLen cells, one cell per cycle while the row is not frozen, and a finish
// token then sets out_valid_o. Reset (rst_ni low, asynchronous) empties both strings.
// A finish token that reaches the end while the output register is full and
// stalled freezes the whole row and stalls the input.
module edit_distance_engine import edc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      symbol_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [OutW-1:0] distance_o,
  output logic [OutW-1:0] longer_length_o,
  output logic            input_error_o
);

  tok_t chain [MaxLen+1];
  logic en;
  logic freeze;

  logic            out_valid_q;
  logic [OutW-1:0] dist_q, longer_q;
  logic            err_q;

  assign freeze     = out_valid_q && out_stall_i && (chain[MaxLen].kind == TokFinish);
  assign en         = !freeze;
  assign in_stall_o = freeze;

  edc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (in_valid_i && !in_stall_o),
    .mode_i   (mode_i),
    .symbol_i (symbol_i),
    .tok_o    (chain[0])
  );

  for (genvar g = 0; g < MaxLen; g++) begin : g_cell
    edc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .index_i (len_t'(g + 1)),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (en && chain[MaxLen].kind == TokFinish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && chain[MaxLen].kind == TokFinish) begin
      dist_q   <= fit_out(chain[MaxLen].distance);
      longer_q <= fit_out(chain[MaxLen].longer);
      err_q    <= chain[MaxLen].err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign distance_o      = dist_q;
  assign longer_length_o = longer_q;
  assign input_error_o   = err_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o <= longer_length_o)
    else $error("distance exceeds longer length");

  a_freeze_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freeze |=> chain[MaxLen].kind == TokFinish && out_valid_o)
    else $error("frozen row lost its finish token");

endmodule
